### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define HMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define HMQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### rtl/hmq_pkg.sv
// Shared types and constants of the height map query block.
package hmq_pkg;

  localparam int MAX_RES   = 256;
  localparam int CELL_W    = $clog2(MAX_RES);
  localparam int ERES_W    = CELL_W + 1;
  localparam int FRAC_W    = 16;
  localparam int DIV_STEPS = CELL_W + FRAC_W;
  localparam int ADDR_W    = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int BYTE_W    = 8;
  localparam int RES_W     = 9;
  localparam int EXT_W     = 31;
  localparam int POS_W     = 32;
  localparam int OFS_W     = POS_W + 1;
  localparam int HEIGHT_W  = 22;
  localparam int WGT_W     = FRAC_W + 1;
  localparam int PRD_W     = WGT_W + BYTE_W;
  localparam int SUM_W     = PRD_W + 2;
  localparam int V_W       = 30;
  localparam int RECIP_W   = 31;
  localparam int RECIP_SHIFT = 38;
  localparam int MUL_W     = V_W + RECIP_W;
  localparam int Q_W       = MUL_W - RECIP_SHIFT;

  localparam logic [RECIP_W-1:0] RECIP_255  = 31'd1077952577;
  localparam logic [WGT_W-1:0]   ONE_Q16    = 17'h10000;
  localparam int                 HEIGHT_MAX = 1638400;
  localparam int                 HEIGHT_SCALE = 50;
  localparam int                 ROUND_BIAS   = 127;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Z = 2'd1,
    CFG_EXTENT   = 2'd2,
    CFG_RES      = 2'd3
  } cfg_idx_t;

  // Control that travels along the pipeline with each transaction
  typedef struct packed {
    logic                vld;
    kind_t               kind;
    logic                oor;
    logic [ADDR_W-1:0]   idx;
    logic [BYTE_W-1:0]   red;
  } tag_t;

endpackage

### rtl/hmq_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module hmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read while en is high
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/hmq_split.sv
// Pipelined scaling divider: splits both offsets into cell index and fraction.
module hmq_split
  import hmq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  tag_t                    in_tag,
  input  logic signed [OFS_W-1:0] ofs_x,
  input  logic signed [OFS_W-1:0] ofs_z,
  input  logic [EXT_W-1:0]        ext,
  input  logic [CELL_W-1:0]       cells,
  output tag_t                    out_tag,
  output logic [CELL_W-1:0]       gx,
  output logic [CELL_W-1:0]       gz,
  output logic [FRAC_W-1:0]       fx,
  output logic [FRAC_W-1:0]       fz
);

  typedef struct packed {
    tag_t                  tag;
    logic [EXT_W-1:0]      rx;
    logic [EXT_W-1:0]      rz;
    logic [CELL_W-1:0]     lx;
    logic [CELL_W-1:0]     lz;
    logic [DIV_STEPS-1:0]  qx;
    logic [DIV_STEPS-1:0]  qz;
  } div_st_t;

  // One restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [EXT_W:0] div_step(input logic [EXT_W-1:0] r,
                                              input logic b,
                                              input logic [EXT_W-1:0] d);
    logic [EXT_W:0]   t;
    logic [EXT_W+1:0] s;
    t = {r, b};
    s = {1'b0, t} - {2'b00, d};
    if (!s[EXT_W+1]) begin
      div_step = {1'b1, s[EXT_W-1:0]};
    end else begin
      div_step = {1'b0, t[EXT_W-1:0]};
    end
  endfunction

  function automatic div_st_t stage_step(input div_st_t s, input logic [EXT_W-1:0] d);
    div_st_t        n;
    logic [EXT_W:0] nx;
    logic [EXT_W:0] nz;
    nx = div_step(s.rx, s.lx[CELL_W-1], d);
    nz = div_step(s.rz, s.lz[CELL_W-1], d);
    n     = s;
    n.rx  = nx[EXT_W-1:0];
    n.rz  = nz[EXT_W-1:0];
    n.lx  = s.lx << 1;
    n.lz  = s.lz << 1;
    n.qx  = {s.qx[DIV_STEPS-2:0], nx[EXT_W]};
    n.qz  = {s.qz[DIV_STEPS-2:0], nz[EXT_W]};
    return n;
  endfunction

  div_st_t st_r   [DIV_STEPS+1];
  div_st_t st_nxt [DIV_STEPS+1];

  logic                      neg_x, neg_z, ge_x, ge_z;
  logic [EXT_W+CELL_W-1:0]   sc_x, sc_z;

  // Range check and scaling by the cell count
  always_comb begin
    neg_x = ofs_x[OFS_W-1];
    neg_z = ofs_z[OFS_W-1];
    ge_x  = ofs_x[OFS_W-2:0] >= {1'b0, ext};
    ge_z  = ofs_z[OFS_W-2:0] >= {1'b0, ext};
    sc_x  = {{CELL_W{1'b0}}, ofs_x[EXT_W-1:0]} * {{EXT_W{1'b0}}, cells};
    sc_z  = {{CELL_W{1'b0}}, ofs_z[EXT_W-1:0]} * {{EXT_W{1'b0}}, cells};
  end

  // Build the first stage and one divide step per stage after it
  always_comb begin
    st_nxt[0].tag     = in_tag;
    st_nxt[0].tag.oor = neg_x | neg_z | ge_x | ge_z;
    st_nxt[0].rx      = sc_x[EXT_W+CELL_W-1:CELL_W];
    st_nxt[0].rz      = sc_z[EXT_W+CELL_W-1:CELL_W];
    st_nxt[0].lx      = sc_x[CELL_W-1:0];
    st_nxt[0].lz      = sc_z[CELL_W-1:0];
    st_nxt[0].qx      = '0;
    st_nxt[0].qz      = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      st_nxt[i+1] = stage_step(st_r[i], ext);
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        st_r[i].tag.vld <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_tag = st_r[DIV_STEPS].tag;
  assign gx      = st_r[DIV_STEPS].qx[DIV_STEPS-1:FRAC_W];
  assign gz      = st_r[DIV_STEPS].qz[DIV_STEPS-1:FRAC_W];
  assign fx      = st_r[DIV_STEPS].qx[FRAC_W-1:0];
  assign fz      = st_r[DIV_STEPS].qz[FRAC_W-1:0];

endmodule

### rtl/heightmap_triangle_height_query_top.sv
// Height map store with pipelined triangle height interpolation.
// Throughput: one transaction per cycle unless out_stall holds a result; the divider steps one bit per stage and
// two dual-read RAM copies deliver all four cell corners in one access.
// Loads write the store in order with queries, at the address stage; the store is not cleared.
// Reset (synchronous, rst_n low) empties the pipeline and loads register defaults.
module heightmap_triangle_height_query_top
  import hmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [POS_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [ADDR_W-1:0]        in_sample_index,
  input  logic [BYTE_W-1:0]        in_red_byte,
  input  logic signed [POS_W-1:0]  in_world_x,
  input  logic signed [POS_W-1:0]  in_world_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_in_range,
  output logic signed [HEIGHT_W-1:0] out_height
);

  logic signed [POS_W-1:0] origin_x_r, origin_z_r;
  logic [EXT_W-1:0]        extent_r;
  logic [RES_W-1:0]        res_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_z_r <= '0;
      extent_r   <= EXT_W'(52428800);
      res_r      <= RES_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        CFG_ORIGIN_Z: origin_z_r <= cfg_wdata;
        CFG_EXTENT:   extent_r   <= cfg_wdata[EXT_W-1:0];
        CFG_RES:      res_r      <= cfg_wdata[RES_W-1:0];
        default:      ;
      endcase
    end
  end

  // Effective extent and resolution
  logic [EXT_W-1:0]  ext_eff;
  logic [ERES_W-1:0] res_eff;
  logic [CELL_W-1:0] cells;
  logic [31:0]       res_wide;

  always_comb begin
    ext_eff  = (extent_r == '0) ? EXT_W'(1) : extent_r;
    res_wide = 32'(res_r);
    if (res_wide < 32'd2) begin
      res_eff = ERES_W'(2);
    end else if (res_wide > 32'(MAX_RES)) begin
      res_eff = ERES_W'(MAX_RES);
    end else begin
      res_eff = ERES_W'(res_wide);
    end
    cells = CELL_W'(res_eff - ERES_W'(1));
  end

  // Global advance: the whole pipeline moves unless the result is held
  logic out_valid_r, out_in_range_r;
  logic signed [HEIGHT_W-1:0] out_height_r;
  logic advance;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // Input stage: subtract the origin
  tag_t                    p1_tag_r;
  logic signed [OFS_W-1:0] p1_ofs_x_r, p1_ofs_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_tag_r.vld <= 1'b0;
    end else if (advance) begin
      p1_tag_r.vld  <= in_valid;
      p1_tag_r.kind <= kind_t'(in_kind);
      p1_tag_r.oor  <= 1'b0;
      p1_tag_r.idx  <= in_sample_index;
      p1_tag_r.red  <= in_red_byte;
      p1_ofs_x_r    <= OFS_W'(in_world_x) - OFS_W'(origin_x_r);
      p1_ofs_z_r    <= OFS_W'(in_world_z) - OFS_W'(origin_z_r);
    end
  end

  // Cell and fraction
  tag_t              sp_tag;
  logic [CELL_W-1:0] sp_gx, sp_gz;
  logic [FRAC_W-1:0] sp_fx, sp_fz;

  hmq_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .in_tag  (p1_tag_r),
    .ofs_x   (p1_ofs_x_r),
    .ofs_z   (p1_ofs_z_r),
    .ext     (ext_eff),
    .cells   (cells),
    .out_tag (sp_tag),
    .gx      (sp_gx),
    .gz      (sp_gz),
    .fx      (sp_fx),
    .fz      (sp_fz)
  );

  // Address stage: base address of the cell
  tag_t              a_tag_r;
  logic [ADDR_W-1:0] a_base_r;
  logic [FRAC_W-1:0] a_fx_r, a_fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r.vld <= 1'b0;
    end else if (advance) begin
      a_tag_r  <= sp_tag;
      a_base_r <= ADDR_W'(32'(sp_gz) * 32'(res_eff) + 32'(sp_gx));
      a_fx_r   <= sp_fx;
      a_fz_r   <= sp_fz;
    end
  end

  // Corner addresses; loads write both copies at this stage
  logic [ADDR_W-1:0] ra00, ra10, ra01, ra11;
  logic              st_we;
  logic [BYTE_W-1:0] h00, h10, h01, h11;

  assign ra00  = a_base_r;
  assign ra10  = a_base_r + ADDR_W'(1);
  assign ra01  = a_base_r + ADDR_W'(res_eff);
  assign ra11  = ra01 + ADDR_W'(1);
  assign st_we = advance && a_tag_r.vld && (a_tag_r.kind == KIND_LOAD);

  hmq_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_ram_lo (
    .clk     (clk),
    .en      (advance),
    .we      (st_we),
    .waddr   (a_tag_r.idx),
    .wdata   (a_tag_r.red),
    .raddr_a (ra00),
    .raddr_b (ra10),
    .rdata_a (h00),
    .rdata_b (h10)
  );

  hmq_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_ram_hi (
    .clk     (clk),
    .en      (advance),
    .we      (st_we),
    .waddr   (a_tag_r.idx),
    .wdata   (a_tag_r.red),
    .raddr_a (ra01),
    .raddr_b (ra11),
    .rdata_a (h01),
    .rdata_b (h11)
  );

  // RAM stage: fractions travel alongside the read data
  tag_t              b_tag_r;
  logic [FRAC_W-1:0] b_fx_r, b_fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r.vld <= 1'b0;
    end else if (advance) begin
      b_tag_r <= a_tag_r;
      b_fx_r  <= a_fx_r;
      b_fz_r  <= a_fz_r;
    end
  end

  // Pick the triangle and form the barycentric weights
  logic [WGT_W-1:0] fx_w, fz_w, fsum, w00, w10, w01, w11;

  always_comb begin
    fx_w = WGT_W'(b_fx_r);
    fz_w = WGT_W'(b_fz_r);
    fsum = fx_w + fz_w;
    if (fsum <= ONE_Q16) begin
      w00 = ONE_Q16 - fsum;
      w10 = fx_w;
      w01 = fz_w;
      w11 = '0;
    end else begin
      w00 = '0;
      w10 = ONE_Q16 - fz_w;
      w01 = ONE_Q16 - fx_w;
      w11 = fsum - ONE_Q16;
    end
  end

  tag_t             c_tag_r;
  logic [PRD_W-1:0] c_p00_r, c_p10_r, c_p01_r, c_p11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_tag_r.vld <= 1'b0;
    end else if (advance) begin
      c_tag_r <= b_tag_r;
      c_p00_r <= PRD_W'(w00) * PRD_W'(h00);
      c_p10_r <= PRD_W'(w10) * PRD_W'(h10);
      c_p01_r <= PRD_W'(w01) * PRD_W'(h01);
      c_p11_r <= PRD_W'(w11) * PRD_W'(h11);
    end
  end

  // Sum, scale by 50 and add the rounding bias
  logic [SUM_W-1:0] c_sum;
  tag_t             d_tag_r;
  logic [V_W-1:0]   d_v_r;

  assign c_sum = SUM_W'(c_p00_r) + SUM_W'(c_p10_r) + SUM_W'(c_p01_r) + SUM_W'(c_p11_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_tag_r.vld <= 1'b0;
    end else if (advance) begin
      d_tag_r <= c_tag_r;
      d_v_r   <= V_W'(32'(c_sum) * 32'(HEIGHT_SCALE) + 32'(ROUND_BIAS));
    end
  end

  // Divide by 255 through the reciprocal
  tag_t             e_tag_r;
  logic [MUL_W-1:0] e_mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_tag_r.vld <= 1'b0;
    end else if (advance) begin
      e_tag_r <= d_tag_r;
      e_mul_r <= MUL_W'(d_v_r) * MUL_W'(RECIP_255);
    end
  end

  // Remove the offset and saturate
  logic [Q_W-1:0]          q_val;
  logic signed [Q_W:0]     h_full;
  logic signed [HEIGHT_W-1:0] h_sat;

  always_comb begin
    q_val  = e_mul_r[MUL_W-1:RECIP_SHIFT];
    h_full = $signed({1'b0, q_val}) - (Q_W+1)'(HEIGHT_MAX);
    if (h_full > $signed((Q_W+1)'(HEIGHT_MAX))) begin
      h_sat = HEIGHT_W'(HEIGHT_MAX);
    end else if (h_full < -$signed((Q_W+1)'(HEIGHT_MAX))) begin
      h_sat = -HEIGHT_W'(HEIGHT_MAX);
    end else begin
      h_sat = h_full[HEIGHT_W-1:0];
    end
  end

  // Output register: hold while stalled, drop load transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r    <= e_tag_r.vld && (e_tag_r.kind == KIND_QUERY);
      out_in_range_r <= !e_tag_r.oor;
      out_height_r   <= e_tag_r.oor ? '0 : h_sat;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_in_range = out_in_range_r;
  assign out_height   = out_height_r;

endmodule

### rtl/hmq_checker.sv
// Port-level checker for the height map query block, with its bind.
`include "assert_macros.svh"

module hmq_checker
  import hmq_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_in_range,
  input logic signed [HEIGHT_W-1:0] out_height
);

  localparam logic signed [HEIGHT_W-1:0] H_LIM = HEIGHT_W'(HEIGHT_MAX);

  // A held result stays valid
  `HMQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

  // Input backs up only behind a held result
  `HMQ_ASSERT(a_stall_src, in_stall |-> out_valid && out_stall, "input stalled without cause")

  // A miss reports zero height
  `HMQ_ASSERT(a_miss_zero, out_valid && !out_in_range |-> out_height == '0, "miss with height")

  // A hit stays inside the height range
  `HMQ_ASSERT_NEVER(a_hit_range, out_valid && ((out_height > H_LIM) || (out_height < -H_LIM)), "height out of range")

endmodule

bind heightmap_triangle_height_query_top hmq_checker u_hmq_checker (.*);
